// ===== sv/pebw_pkg.sv =====
// Shared constants, types and helpers for the particle Euler step core.
`default_nettype none
package pebw_pkg;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_X_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_X_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RESTITUTION = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 3'd6;
   localparam int unsigned REQ_W = 224;
   localparam int unsigned RSP_W = 128;
   localparam int unsigned DIV_STEPS = 48;

   typedef struct packed {
      logic signed [31:0] lox;
      logic signed [31:0] hix;
      logic signed [31:0] loy;
      logic signed [31:0] hiy;
      logic [17:0]        rest1;
      logic [23:0]        dt100;
      logic               ovf;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic ovf32(input logic signed [63:0] v);
      return (v > 64'sd2147483647) || (v < -64'sd2147483648);
   endfunction
endpackage
`default_nettype wire

// ===== sv/pebw_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, signed truncation.
`default_nettype none
module pebw_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic signed [31:0]  num,
   input  wire logic [30:0]         den,
   output logic signed [63:0]       quo
);
   import pebw_pkg::*;
   // Stage k holds remainder, remaining dividend bits and the quotient so far.
   logic [47:0] rem_ff [DIV_STEPS+1];
   logic [47:0] dvd_ff [DIV_STEPS+1];
   logic [30:0] den_ff [DIV_STEPS+1];
   logic        neg_ff [DIV_STEPS+1];
   logic [47:0] rem_in [DIV_STEPS];
   logic [47:0] dvd_in [DIV_STEPS];
   logic [48:0] trial  [DIV_STEPS];

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial[k] = {rem_ff[k], dvd_ff[k][47]} - {18'd0, den_ff[k]};
         if (!trial[k][48]) begin
            rem_in[k] = trial[k][47:0];
            dvd_in[k] = {dvd_ff[k][46:0], 1'b1};
         end else begin
            rem_in[k] = {rem_ff[k][46:0], dvd_ff[k][47]};
            dvd_in[k] = {dvd_ff[k][46:0], 1'b0};
         end
      end
   end

   logic [31:0] mag;
   assign mag = num[31] ? (~num + 32'd1) : num;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         dvd_ff[0] <= {mag, 16'd0};
         den_ff[0] <= den;
         neg_ff[0] <= num[31];
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k+1] <= rem_in[k];
            dvd_ff[k+1] <= dvd_in[k];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   assign quo = neg_ff[DIV_STEPS] ? -$signed({16'd0, dvd_ff[DIV_STEPS]})
                                  : $signed({16'd0, dvd_ff[DIV_STEPS]});
   logic unused;
   assign unused = reset;
endmodule
`default_nettype wire

// ===== sv/particle_euler_step_wall_bounce_core.sv =====
// Top level: Euler step, box clamp and wall reflection, fully pipelined.
`default_nettype none
// Channel | Dir | Word contents
// req_    | in  | force_x, force_y, density(31b+pad), pos_x, pos_y, vel_x, vel_y
// rsp_    | out | new_pos_x, new_pos_y, new_vel_x, new_vel_y; tuser = overflow
// csr_    | in  | write enable, index, 32-bit data
// One word enters per cycle while rsp_ is not stalled. A word reaches rsp_
// through the divider input register, loaded on its accepting edge, then 48
// quotient stages and ten arithmetic stages. Reset clears all valid bits,
// loads default registers and holds req_tready low. A stall on rsp_ freezes
// the whole pipeline; a word is never lost or repeated because every stage
// advances on the same enable.
module particle_euler_step_wall_bounce_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic [pebw_pkg::CSR_IDX_W-1:0] csr_idx,
   input  wire logic [pebw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // force_x[31:0] force_y[63:32] density[94:64] pad[95] pos_x[127:96]
   // pos_y[159:128] vel_x[191:160] vel_y[223:192]
   input  wire logic [pebw_pkg::REQ_W-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // new_pos_x[31:0] new_pos_y[63:32] new_vel_x[95:64] new_vel_y[127:96]
   output logic [pebw_pkg::RSP_W-1:0] rsp_tdata,
   // overflow
   output logic      rsp_tuser
);
   import pebw_pkg::*;
   localparam int unsigned NA = 10;
   localparam int unsigned LAT = DIV_STEPS + 1;

   logic signed [31:0] bxl_ff, bxh_ff, byl_ff, byh_ff;
   logic [30:0] rad_ff;
   logic [16:0] rst_ff, dt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bxl_ff <= 0; bxh_ff <= 32'sd6553600; byl_ff <= 0; byh_ff <= 32'sd6553600;
         rad_ff <= 31'd65536; rst_ff <= 17'd32768; dt_ff <= 17'd1092;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_BOX_X_MIN: bxl_ff <= csr_wdata;
            REG_BOX_X_MAX: bxh_ff <= csr_wdata;
            REG_BOX_Y_MIN: byl_ff <= csr_wdata;
            REG_BOX_Y_MAX: byh_ff <= csr_wdata;
            REG_RADIUS:    rad_ff <= csr_wdata[30:0];
            REG_RESTITUTION: rst_ff <= csr_wdata[16:0];
            REG_TIME_STEP: dt_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Derived configuration; the user keeps it stable while the block is idle.
   cfg_type cfg;
   logic signed [63:0] lx, hx, ly, hy;
   always_comb begin
      lx = 64'(bxl_ff) + $signed({33'd0, rad_ff});
      hx = 64'(bxh_ff) - $signed({33'd0, rad_ff});
      ly = 64'(byl_ff) + $signed({33'd0, rad_ff});
      hy = 64'(byh_ff) - $signed({33'd0, rad_ff});
      cfg.lox = sat32(lx); cfg.hix = sat32(hx);
      cfg.loy = sat32(ly); cfg.hiy = sat32(hy);
      cfg.ovf = ovf32(lx) | ovf32(hx) | ovf32(ly) | ovf32(hy);
      cfg.rest1 = 18'd65536 + {1'b0, rst_ff};
      cfg.dt100 = 24'(dt_ff) * 24'd100;
   end

   logic en;
   logic [NA-1:0] v_ff;
   logic [LAT-1:0] dv_ff;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0; v_ff <= '0;
      end else if (en) begin
         dv_ff <= {dv_ff[LAT-2:0], req_tvalid};
         v_ff <= {v_ff[NA-2:0], dv_ff[LAT-1]};
      end
   end
   assign rsp_tvalid = v_ff[NA-1];

   // Payload side line alongside the dividers: zero-density flag on top,
   // then vel_y, vel_x, pos_y, pos_x down to bit 0.
   logic [128:0] sl_ff [LAT];
   logic         zd;
   assign zd = req_tdata[94:64] == 31'd0;
   always_ff @(posedge clock) begin
      if (en) begin
         sl_ff[0] <= {zd, req_tdata[223:96]};
         for (int k = 1; k < LAT; k++) sl_ff[k] <= sl_ff[k-1];
      end
   end
   logic signed [63:0] qx, qy;
   pebw_div u_divx (.clock, .reset, .en, .num(req_tdata[31:0]),
                    .den(zd ? 31'd1 : req_tdata[94:64]), .quo(qx));
   pebw_div u_divy (.clock, .reset, .en, .num(req_tdata[63:32]),
                    .den(zd ? 31'd1 : req_tdata[94:64]), .quo(qy));

   logic [128:0] s;
   assign s = sl_ff[LAT-1];
   logic signed [31:0] ipx, ipy, ivx, ivy;
   logic zds;
   assign ipx = s[31:0]; assign ipy = s[63:32];
   assign ivx = s[95:64]; assign ivy = s[127:96];
   assign zds = s[128];

   // Stage A0: acceleration.
   logic signed [31:0] ax_ff, ay_ff, a_vx_ff, a_vy_ff, a_px_ff, a_py_ff;
   logic a_o_ff;
   // With zero density the dividers ran with a divisor of one, so the
   // quotient carries the sign of the force; the acceleration is then the
   // extreme of that sign, and any nonzero force counts as an overflow.
   always_ff @(posedge clock) begin
      if (en) begin
         if (zds) begin
            ax_ff <= (qx > 0) ? 32'sh7fffffff : ((qx < 0) ? 32'sh80000000 : 32'sd0);
            ay_ff <= (qy > 0) ? 32'sh7fffffff : ((qy < 0) ? 32'sh80000000 : 32'sd0);
            a_o_ff <= (qx != 0) | (qy != 0) | cfg.ovf;
         end else begin
            ax_ff <= sat32(qx); ay_ff <= sat32(qy);
            a_o_ff <= ovf32(qx) | ovf32(qy) | cfg.ovf;
         end
         a_vx_ff <= ivx; a_vy_ff <= ivy; a_px_ff <= ipx; a_py_ff <= ipy;
      end
   end

   // Stage A1: accel times dt100.
   logic signed [63:0] mx_ff, my_ff;
   logic signed [31:0] b_vx_ff, b_vy_ff, b_px_ff, b_py_ff;
   logic b_o_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= 64'(ax_ff) * $signed({40'd0, cfg.dt100});
         my_ff <= 64'(ay_ff) * $signed({40'd0, cfg.dt100});
         b_vx_ff <= a_vx_ff; b_vy_ff <= a_vy_ff;
         b_px_ff <= a_px_ff; b_py_ff <= a_py_ff; b_o_ff <= a_o_ff;
      end
   end

   // Stage A2: velocity update.
   logic signed [63:0] nvx, nvy;
   logic signed [31:0] c_vx_ff, c_vy_ff, c_px_ff, c_py_ff;
   logic c_o_ff;
   assign nvx = 64'(b_vx_ff) + (mx_ff >>> 16);
   assign nvy = 64'(b_vy_ff) + (my_ff >>> 16);
   always_ff @(posedge clock) begin
      if (en) begin
         c_vx_ff <= sat32(nvx); c_vy_ff <= sat32(nvy);
         c_o_ff <= b_o_ff | ovf32(nvx) | ovf32(nvy);
         c_px_ff <= b_px_ff; c_py_ff <= b_py_ff;
      end
   end

   // Stage A3: velocity times dt100.
   logic signed [63:0] px_m_ff, py_m_ff;
   logic signed [31:0] d_vx_ff, d_vy_ff, d_px_ff, d_py_ff;
   logic d_o_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         px_m_ff <= 64'(c_vx_ff) * $signed({40'd0, cfg.dt100});
         py_m_ff <= 64'(c_vy_ff) * $signed({40'd0, cfg.dt100});
         d_vx_ff <= c_vx_ff; d_vy_ff <= c_vy_ff;
         d_px_ff <= c_px_ff; d_py_ff <= c_py_ff; d_o_ff <= c_o_ff;
      end
   end

   // Stage A4: position update.
   logic signed [63:0] npx, npy;
   logic signed [31:0] e_vx_ff, e_vy_ff, e_px_ff, e_py_ff;
   logic e_o_ff;
   assign npx = 64'(d_px_ff) + (px_m_ff >>> 16);
   assign npy = 64'(d_py_ff) + (py_m_ff >>> 16);
   always_ff @(posedge clock) begin
      if (en) begin
         e_px_ff <= sat32(npx); e_py_ff <= sat32(npy);
         e_o_ff <= d_o_ff | ovf32(npx) | ovf32(npy);
         e_vx_ff <= d_vx_ff; e_vy_ff <= d_vy_ff;
      end
   end

   // Stage A5: wall tests in order x low, y low, x high, y high.
   logic signed [1:0] nx_in, ny_in, f_nx_ff, f_ny_ff;
   logic signed [31:0] cpx, cpy, f_px_ff, f_py_ff, f_vx_ff, f_vy_ff;
   logic f_o_ff;
   always_comb begin
      nx_in = '0; ny_in = '0; cpx = e_px_ff; cpy = e_py_ff;
      if (cpx < cfg.lox) begin nx_in = nx_in + 2'sd1; cpx = cfg.lox; end
      if (cpy < cfg.loy) begin ny_in = ny_in + 2'sd1; cpy = cfg.loy; end
      if (cpx > cfg.hix) begin nx_in = nx_in - 2'sd1; cpx = cfg.hix; end
      if (cpy > cfg.hiy) begin ny_in = ny_in - 2'sd1; cpy = cfg.hiy; end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         f_nx_ff <= nx_in; f_ny_ff <= ny_in; f_px_ff <= cpx; f_py_ff <= cpy;
         f_vx_ff <= e_vx_ff; f_vy_ff <= e_vy_ff; f_o_ff <= e_o_ff;
      end
   end

   // Stage A6: dot product with the normal.
   logic signed [33:0] dd_ff;
   logic signed [1:0] g_nx_ff, g_ny_ff;
   logic signed [31:0] g_px_ff, g_py_ff, g_vx_ff, g_vy_ff;
   logic g_o_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff <= 34'(f_vx_ff) * 34'(f_nx_ff) + 34'(f_vy_ff) * 34'(f_ny_ff);
         g_nx_ff <= f_nx_ff; g_ny_ff <= f_ny_ff; g_px_ff <= f_px_ff;
         g_py_ff <= f_py_ff; g_vx_ff <= f_vx_ff; g_vy_ff <= f_vy_ff; g_o_ff <= f_o_ff;
      end
   end

   // Stage A7: scale by one plus restitution.
   logic signed [63:0] pr_ff;
   logic signed [1:0] h_nx_ff, h_ny_ff;
   logic signed [31:0] h_px_ff, h_py_ff, h_vx_ff, h_vy_ff;
   logic h_o_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff <= 64'(dd_ff) * $signed({46'd0, cfg.rest1});
         h_nx_ff <= g_nx_ff; h_ny_ff <= g_ny_ff; h_px_ff <= g_px_ff;
         h_py_ff <= g_py_ff; h_vx_ff <= g_vx_ff; h_vy_ff <= g_vy_ff; h_o_ff <= g_o_ff;
      end
   end

   // Stage A8: reflect. A normal component is -1, 0 or +1, so the product
   // with q reduces to an add, a subtract or nothing.
   logic signed [63:0] q, rvx, rvy;
   logic hit;
   logic signed [31:0] i_px_ff, i_py_ff, i_vx_ff, i_vy_ff;
   logic i_o_ff;
   assign hit = (h_nx_ff != 0) || (h_ny_ff != 0);
   assign q = (h_nx_ff != 0 && h_ny_ff != 0) ? (pr_ff >>> 17) : (pr_ff >>> 16);
   assign rvx = h_nx_ff[1] ? (64'(h_vx_ff) + q)
                           : (h_nx_ff[0] ? (64'(h_vx_ff) - q) : 64'(h_vx_ff));
   assign rvy = h_ny_ff[1] ? (64'(h_vy_ff) + q)
                           : (h_ny_ff[0] ? (64'(h_vy_ff) - q) : 64'(h_vy_ff));
   always_ff @(posedge clock) begin
      if (en) begin
         i_px_ff <= h_px_ff; i_py_ff <= h_py_ff;
         i_vx_ff <= hit ? sat32(rvx) : h_vx_ff;
         i_vy_ff <= hit ? sat32(rvy) : h_vy_ff;
         i_o_ff <= h_o_ff | (hit & (ovf32(rvx) | ovf32(rvy)));
      end
   end

   // Stage A9: output register.
   logic [127:0] o_ff;
   logic o_o_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         o_ff <= {i_vy_ff, i_vx_ff, i_py_ff, i_px_ff};
         o_o_ff <= i_o_ff;
      end
   end
   assign rsp_tdata = o_ff;
   assign rsp_tuser = o_o_ff;

   logic unused;
   assign unused = req_tdata[95];

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("ready dropped with empty output");
   a_mov: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff)) else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
